[rtl/rfnt_pkg.sv]
// ----------------------------------------------------------------------------
// rfnt_pkg
// Shared types and constants for the RAM file node table.
// ----------------------------------------------------------------------------
package rfnt_pkg;

    localparam int NODE_COUNT = 8;
    localparam int FILE_BYTES = 128;
    localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SIZE_W     = $clog2(FILE_BYTES);
    localparam int MEM_DEPTH  = NODE_COUNT * FILE_BYTES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int CMP_W      = ((SIZE_W > 8) ? SIZE_W : 8) + 1;
    localparam int LIMIT      = FILE_BYTES - 1;

    localparam int IDX_W  = 3;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 3;
    localparam int STS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_MAKE   = 3'd0,
        REQ_LINK   = 3'd1,
        REQ_UNLINK = 3'd2,
        REQ_GETREF = 3'd3,
        REQ_DROP   = 3'd4,
        REQ_WRITE  = 3'd5,
        REQ_READ   = 3'd6
    } t_req;

    typedef enum logic [STS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NONODE = 2'd2,
        ST_EOF    = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic out_busy;
    } t_sts;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] idx,
                                                   input logic [BYTE_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(idx) * ADDR_W'(FILE_BYTES);
        return base + ADDR_W'(pos);
    endfunction

endpackage

[rtl/rfnt_ram.sv]
// ----------------------------------------------------------------------------
// rfnt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rfnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rfnt_ctrl.sv]
// ----------------------------------------------------------------------------
// rfnt_ctrl
// Sequencer: memory clear after reset, request load, execute.
// ----------------------------------------------------------------------------
module rfnt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rfnt_pkg::t_sts i_sts,
    output rfnt_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/rfnt_dpath.sv]
// ----------------------------------------------------------------------------
// rfnt_dpath
// Node metadata, file byte memory, request latch and result register.
// ----------------------------------------------------------------------------
module rfnt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rfnt_pkg::t_cmd                i_cmd,
    output rfnt_pkg::t_sts                o_sts,
    input  logic [rfnt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rfnt_pkg::IDX_W-1:0]    i_node_index,
    input  logic [rfnt_pkg::BYTE_W-1:0]   i_byte_pos,
    input  logic [rfnt_pkg::BYTE_W-1:0]   i_write_byte,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [rfnt_pkg::STS_W-1:0]    o_status,
    output logic [rfnt_pkg::IDX_W-1:0]    o_node_out,
    output logic [rfnt_pkg::BYTE_W-1:0]   o_read_byte,
    output logic                          o_byte_count
);

    localparam int NC     = rfnt_pkg::NODE_COUNT;
    localparam int NW     = rfnt_pkg::NODE_W;
    localparam int SW     = rfnt_pkg::SIZE_W;
    localparam int AW     = rfnt_pkg::ADDR_W;
    localparam int CW     = rfnt_pkg::CMP_W;

    // request latch
    logic [rfnt_pkg::REQ_W-1:0]  r_req;
    logic [rfnt_pkg::IDX_W-1:0]  r_idx;
    logic [rfnt_pkg::BYTE_W-1:0] r_pos;
    logic [rfnt_pkg::BYTE_W-1:0] r_wbyte;

    // metadata
    logic [NC-1:0] r_used;
    logic [7:0]    r_ref  [NC];
    logic [7:0]    r_link [NC];
    logic [SW-1:0] r_size [NC];

    logic [AW-1:0] r_clr_cnt;

    // result register
    logic                        r_out_valid;
    logic [rfnt_pkg::STS_W-1:0]  r_out_status;
    logic [rfnt_pkg::IDX_W-1:0]  r_out_node;
    logic [rfnt_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_count;

    // memory port
    logic                        w_mem_we;
    logic                        w_mem_re;
    logic [AW-1:0]               w_mem_addr;
    logic [rfnt_pkg::BYTE_W-1:0] w_mem_wdata;
    logic [rfnt_pkg::BYTE_W-1:0] w_mem_rdata;

    // execute decode
    logic          w_free_found;
    logic [NW-1:0] w_free_idx;
    logic [NW-1:0] w_nidx;
    logic          w_present;
    logic          w_past_limit;
    logic          w_past_size;
    logic [CW-1:0] w_pos_ext;
    logic [7:0]    w_link_dec;
    logic [7:0]    w_ref_dec;

    logic                        n_status_ok;
    rfnt_pkg::t_status           n_status;
    logic [rfnt_pkg::IDX_W-1:0]  n_node;
    logic [rfnt_pkg::BYTE_W-1:0] n_rbyte;
    logic                        n_count;
    logic                        n_do_make;
    logic                        n_do_link;
    logic                        n_do_unlink;
    logic                        n_do_getref;
    logic                        n_do_drop;
    logic                        n_do_write;

    rfnt_ram #(
        .WIDTH (rfnt_pkg::BYTE_W),
        .DEPTH (rfnt_pkg::MEM_DEPTH)
    ) u_bytes (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = NC - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = NW'(i);
            end
        end
    end

    assign w_nidx       = NW'(r_idx);
    assign w_present    = (32'(r_idx) < 32'(NC)) && r_used[w_nidx];
    assign w_pos_ext    = CW'(r_pos);
    assign w_past_limit = w_pos_ext >= CW'(rfnt_pkg::LIMIT);
    assign w_past_size  = w_pos_ext >= CW'(r_size[w_nidx]);
    assign w_link_dec   = r_link[w_nidx] - 8'd1;
    assign w_ref_dec    = r_ref[w_nidx] - 8'd1;

    always_comb begin
        n_status    = rfnt_pkg::ST_OK;
        n_node      = r_idx;
        n_rbyte     = '0;
        n_count     = 1'b0;
        n_do_make   = 1'b0;
        n_do_link   = 1'b0;
        n_do_unlink = 1'b0;
        n_do_getref = 1'b0;
        n_do_drop   = 1'b0;
        n_do_write  = 1'b0;
        case (r_req)
            rfnt_pkg::REQ_MAKE: begin
                if (w_free_found) begin
                    n_node    = rfnt_pkg::IDX_W'(w_free_idx);
                    n_do_make = 1'b1;
                end else begin
                    n_node   = '0;
                    n_status = rfnt_pkg::ST_FULL;
                end
            end
            rfnt_pkg::REQ_LINK, rfnt_pkg::REQ_UNLINK,
            rfnt_pkg::REQ_GETREF, rfnt_pkg::REQ_DROP: begin
                if (!w_present) begin
                    n_status = rfnt_pkg::ST_NONODE;
                end else begin
                    n_do_link   = (r_req == rfnt_pkg::REQ_LINK);
                    n_do_unlink = (r_req == rfnt_pkg::REQ_UNLINK);
                    n_do_getref = (r_req == rfnt_pkg::REQ_GETREF);
                    n_do_drop   = (r_req == rfnt_pkg::REQ_DROP);
                end
            end
            rfnt_pkg::REQ_WRITE: begin
                if (w_past_limit) begin
                    n_status = rfnt_pkg::ST_EOF;
                end else if (!w_present) begin
                    n_status = rfnt_pkg::ST_NONODE;
                end else begin
                    n_do_write = 1'b1;
                    n_count    = 1'b1;
                end
            end
            rfnt_pkg::REQ_READ: begin
                if (w_past_limit) begin
                    n_status = rfnt_pkg::ST_EOF;
                end else if (!w_present) begin
                    n_status = rfnt_pkg::ST_NONODE;
                end else if (w_past_size) begin
                    n_status = rfnt_pkg::ST_EOF;
                end else begin
                    n_rbyte = w_mem_rdata;
                    n_count = 1'b1;
                end
            end
            default: n_status = rfnt_pkg::ST_OK;
        endcase
        n_status_ok = (n_status == rfnt_pkg::ST_OK);
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = rfnt_pkg::mem_addr(r_idx, r_pos);
        w_mem_wdata = r_wbyte;
        if (i_cmd.clear) begin
            w_mem_we    = 1'b1;
            w_mem_addr  = r_clr_cnt;
            w_mem_wdata = '0;
        end else if (i_cmd.load) begin
            w_mem_re   = 1'b1;
            w_mem_addr = rfnt_pkg::mem_addr(i_node_index, i_byte_pos);
        end else if (i_cmd.exec) begin
            w_mem_we = n_do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_idx   <= i_node_index;
            r_pos   <= i_byte_pos;
            r_wbyte <= i_write_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.exec) begin
            if (n_do_make) begin
                r_used[w_free_idx] <= 1'b1;
            end
            if (n_do_unlink && w_link_dec == 8'd0 && r_ref[w_nidx] == 8'd0) begin
                r_used[w_nidx] <= 1'b0;
            end
            if (n_do_drop && w_ref_dec == 8'd0 && r_link[w_nidx] == 8'd0) begin
                r_used[w_nidx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (n_do_make) begin
                r_ref[w_free_idx]  <= '0;
                r_link[w_free_idx] <= '0;
                r_size[w_free_idx] <= '0;
            end
            if (n_do_link) begin
                r_link[w_nidx] <= r_link[w_nidx] + 8'd1;
            end
            if (n_do_unlink) begin
                r_link[w_nidx] <= w_link_dec;
            end
            if (n_do_getref) begin
                r_ref[w_nidx] <= r_ref[w_nidx] + 8'd1;
            end
            if (n_do_drop) begin
                r_ref[w_nidx] <= w_ref_dec;
            end
            if (n_do_write) begin
                r_size[w_nidx] <= SW'(w_pos_ext + CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= n_status;
            r_out_node   <= n_node;
            r_out_byte   <= n_status_ok ? n_rbyte : '0;
            r_out_count  <= n_status_ok & n_count;
        end
    end

    assign o_sts.clr_done = i_cmd.clear && (r_clr_cnt == AW'(rfnt_pkg::MEM_DEPTH - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_node_out   = r_out_node;
    assign o_read_byte  = r_out_byte;
    assign o_byte_count = r_out_count;

endmodule

[rtl/ram_file_node_table_unit.sv]
// ----------------------------------------------------------------------------
// ram_file_node_table_unit
// Table of small RAM files: node make, link/unlink, ref get/drop, byte r/w.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                   | tuser
//  s_axis   | in        | node_index, byte_pos, write_byte     | req_type
//  m_axis   | out       | node_out, read_byte, byte_count      | status
//
//  A request runs as load (file memory read issued), then execute
//  (metadata update, file memory write, result register load).
//  After reset the file memory is zeroed, one byte per cycle, for all 1024
//  (NODE_COUNT*FILE_BYTES) bytes with s_axis_tready low.
//  A new request is taken while a result waits; execute stalls until the
//  result register is free.
// ----------------------------------------------------------------------------
module ram_file_node_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // node_index[2:0], byte_pos[10:3], write_byte[18:11]
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // node_out[2:0], read_byte[10:3], byte_count[11]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    rfnt_pkg::t_cmd w_cmd;
    rfnt_pkg::t_sts w_sts;

    logic [rfnt_pkg::IDX_W-1:0]  w_node_out;
    logic [rfnt_pkg::BYTE_W-1:0] w_read_byte;
    logic                        w_byte_count;

    rfnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rfnt_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_type   (s_axis_tuser),
        .i_node_index (s_axis_tdata[2:0]),
        .i_byte_pos   (s_axis_tdata[10:3]),
        .i_write_byte (s_axis_tdata[18:11]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (m_axis_tuser),
        .o_node_out   (w_node_out),
        .o_read_byte  (w_read_byte),
        .o_byte_count (w_byte_count)
    );

    assign m_axis_tdata = {4'b0000, w_byte_count, w_read_byte, w_node_out};

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !s_axis_tready)
        else $error("request accepted during memory clear");

    a_one_cycle_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept without execute");

    a_count_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tuser == rfnt_pkg::ST_OK)
        else $error("byte count set on failed transaction");

    a_byte_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10:3] != 8'd0 |-> m_axis_tuser == rfnt_pkg::ST_OK)
        else $error("read byte nonzero on failed transaction");

endmodule
